// ===== hw/rtl/cgr_pkg.sv =====
// Shared constants and types for the gray-to-RGB colormap ramp.
`timescale 1ns / 1ps
package cgr_pkg;

   // Default number of ramp levels held in the level store
   localparam int MAX_LEVELS_DEF = 5;

   // Quotient bits produced by each divider (Q0.16)
   localparam int QBITS = 16;

   // Number of color channels
   localparam int NUM_CHAN = 3;

   // Register indexes on the write port
   localparam logic [2:0] CSR_RANGE_LOW   = 3'd0;
   localparam logic [2:0] CSR_RANGE_HIGH  = 3'd1;
   localparam logic [2:0] CSR_LEVEL_COUNT = 3'd2;
   localparam logic [2:0] CSR_LEVEL_0     = 3'd3;

   // Field positions inside one level word
   localparam int POS_LSB = 48;

   // Largest Q0.16 value, used for clamped ratios
   localparam logic [15:0] UNIT_MAX = 16'hFFFF;

   // How a ratio is resolved: by division, forced to zero, or saturated
   typedef enum logic [1:0] {
      CLS_DIV,
      CLS_ZERO,
      CLS_SAT
   } cls_type;

   // Low bit of a color channel inside a level word (red, green, blue)
   function automatic int chan_lsb(input int ch);
      chan_lsb = 32 - 16 * ch;
   endfunction

   // Resolve a ratio from its class and the divider quotient
   function automatic logic [15:0] ratio_pick(input cls_type cls, input logic [15:0] quot);
      logic [15:0] r;
      case (cls)
         CLS_DIV:  r = quot;
         CLS_SAT:  r = UNIT_MAX;
         default:  r = 16'd0;
      endcase
      ratio_pick = r;
   endfunction

endpackage

// ===== hw/rtl/cgr_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, elastic handshake.
`timescale 1ns / 1ps
module cgr_div #(
   parameter int W  = 33,
   parameter int SB = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [W-1:0]                in_num,
   input  logic [W-1:0]                in_den,
   input  logic [SB-1:0]               in_side,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [cgr_pkg::QBITS-1:0]   out_quot,
   output logic [SB-1:0]               out_side
);
   import cgr_pkg::*;

   logic             v_ff [QBITS];
   logic [W-1:0]     r_ff [QBITS];
   logic [W-1:0]     d_ff [QBITS];
   logic [QBITS-1:0] q_ff [QBITS];
   logic [SB-1:0]    s_ff [QBITS];
   logic             rdy  [QBITS+1];

   assign rdy[QBITS] = out_ready;
   assign in_ready   = rdy[0];

   genvar k;
   generate
      for (k = 0; k < QBITS; k++) begin : g_stage
         logic             sv;
         logic [W-1:0]     sr, sd;
         logic [QBITS-1:0] sq;
         logic [SB-1:0]    ss;
         logic [W:0]       r2;
         logic             ge;
         logic [W-1:0]     r_in;
         logic [QBITS-1:0] q_in;

         // Take operands from the ports or from the previous stage
         if (k == 0) begin : g_first
            assign sv = in_valid;
            assign sr = in_num;
            assign sd = in_den;
            assign sq = '0;
            assign ss = in_side;
         end else begin : g_next
            assign sv = v_ff[k-1];
            assign sr = r_ff[k-1];
            assign sd = d_ff[k-1];
            assign sq = q_ff[k-1];
            assign ss = s_ff[k-1];
         end

         // Shift the partial remainder and try one subtract
         assign r2   = {sr, 1'b0};
         assign ge   = (r2 >= {1'b0, sd});
         assign r_in = ge ? W'(r2 - {1'b0, sd}) : W'(r2);
         assign q_in = {sq[QBITS-2:0], ge};

         assign rdy[k] = !v_ff[k] || rdy[k+1];

         // Advance when the stage is empty or its item moves on
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (rdy[k]) begin
               v_ff[k] <= sv;
            end
            if (rdy[k] && sv) begin
               r_ff[k] <= r_in;
               d_ff[k] <= sd;
               q_ff[k] <= q_in;
               s_ff[k] <= ss;
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[QBITS-1];
   assign out_quot  = q_ff[QBITS-1];
   assign out_side  = s_ff[QBITS-1];

endmodule

// ===== hw/rtl/cgr_norm.sv =====
// Front stage: forms the normalization numerator and divisor and classifies them.
`timescale 1ns / 1ps
module cgr_norm (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic signed [31:0]  pixel,
   input  logic signed [31:0]  range_low,
   input  logic signed [31:0]  range_high,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [32:0]         out_num,
   output logic [32:0]         out_den,
   output cgr_pkg::cls_type    out_cls
);
   import cgr_pkg::*;

   logic signed [33:0] lo, hi, num_raw, den_raw, num, den;
   cls_type            cls;
   logic               v_ff;
   logic [32:0]        num_ff, den_ff;
   cls_type            cls_ff;

   // Build the signed ratio terms, fold the divisor sign into the numerator
   always_comb begin
      if (range_high == range_low) begin
         lo = 34'sd0;
         hi = 34'sd256;
      end else begin
         lo = 34'(range_low);
         hi = 34'(range_high);
      end
      num_raw = hi - 34'(pixel);
      den_raw = hi - lo;
      if (den_raw < 0) begin
         num = -num_raw;
         den = -den_raw;
      end else begin
         num = num_raw;
         den = den_raw;
      end
      if (num <= 0) begin
         cls = CLS_ZERO;
      end else if (num >= den) begin
         cls = CLS_SAT;
      end else begin
         cls = CLS_DIV;
      end
   end

   assign in_ready = !v_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         num_ff <= num[32:0];
         den_ff <= den[32:0];
         cls_ff <= cls;
      end
   end

   assign out_valid = v_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_cls   = cls_ff;

endmodule

// ===== hw/rtl/cgr_seg.sv =====
// Segment stage: picks the ramp segment and forms the fraction ratio terms.
`timescale 1ns / 1ps
module cgr_seg #(
   parameter int MAX_LEVELS = cgr_pkg::MAX_LEVELS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [cgr_pkg::QBITS-1:0]  in_quot,
   input  cgr_pkg::cls_type           in_cls,
   input  logic [63:0]                level_word [MAX_LEVELS],
   input  logic [2:0]                 level_num,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [15:0]                out_num,
   output logic [15:0]                out_den,
   output cgr_pkg::cls_type           out_cls,
   output logic [1:0]                 out_lev
);
   import cgr_pkg::*;

   localparam int IDX_W = (MAX_LEVELS > 2) ? $clog2(MAX_LEVELS) : 1;

   logic [15:0]        t, p0, p1;
   logic [2:0]         lev;
   logic               go;
   logic signed [16:0] num_raw, den_raw, num, den;
   cls_type            cls;
   logic               v_ff;
   logic [15:0]        num_ff, den_ff;
   cls_type            cls_ff;
   logic [1:0]         lev_ff;

   // Walk the level positions and stop at the first one t has not reached
   always_comb begin
      t   = ratio_pick(in_cls, in_quot);
      lev = 3'd0;
      go  = 1'b1;
      for (int k = 1; k < MAX_LEVELS; k++) begin
         if (go && (3'(k) < level_num) && (t >= level_word[k][POS_LSB +: 16])) begin
            lev = 3'(k);
         end else begin
            go = 1'b0;
         end
      end
      if (lev >= level_num - 3'd1) begin
         lev = lev - 3'd1;
      end
      p0 = level_word[IDX_W'(lev)][POS_LSB +: 16];
      p1 = level_word[IDX_W'(lev + 3'd1)][POS_LSB +: 16];
      num_raw = $signed({1'b0, t}) - $signed({1'b0, p0});
      den_raw = $signed({1'b0, p1}) - $signed({1'b0, p0});
      if (den_raw < 0) begin
         num = -num_raw;
         den = -den_raw;
      end else begin
         num = num_raw;
         den = den_raw;
      end
      if (den == 0 || num <= 0) begin
         cls = CLS_ZERO;
      end else if (num >= den) begin
         cls = CLS_SAT;
      end else begin
         cls = CLS_DIV;
      end
   end

   assign in_ready = !v_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         num_ff <= num[15:0];
         den_ff <= den[15:0];
         cls_ff <= cls;
         lev_ff <= lev[1:0];
      end
   end

   assign out_valid = v_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_cls   = cls_ff;
   assign out_lev   = lev_ff;

endmodule

// ===== hw/rtl/cgr_shade.sv =====
// Shade stages: interpolate each channel, clamp, and scale by 255 into Q8.8.
`timescale 1ns / 1ps
module cgr_shade #(
   parameter int MAX_LEVELS = cgr_pkg::MAX_LEVELS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [cgr_pkg::QBITS-1:0]  in_quot,
   input  cgr_pkg::cls_type           in_cls,
   input  logic [1:0]                 in_lev,
   input  logic [63:0]                level_word [MAX_LEVELS],
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [15:0]                rsp_red,
   output logic [15:0]                rsp_green,
   output logic [15:0]                rsp_blue,
   output logic [1:0]                 rsp_segment_index,
   output logic [15:0]                rsp_segment_fraction
);
   import cgr_pkg::*;

   localparam int IDX_W = (MAX_LEVELS > 2) ? $clog2(MAX_LEVELS) : 1;

   logic               rdy1, rdy2, rdy3;
   logic               v1_ff, v2_ff, v3_ff;
   logic [15:0]        frac;
   logic [15:0]        c0 [NUM_CHAN];
   logic signed [33:0] prod_in [NUM_CHAN];
   logic signed [33:0] prod_ff [NUM_CHAN];
   logic [15:0]        c0_ff [NUM_CHAN];
   logic [15:0]        frac1_ff, frac2_ff, frac3_ff;
   logic [1:0]         lev1_ff, lev2_ff, lev3_ff;
   logic [31:0]        v_in [NUM_CHAN];
   logic [31:0]        v_ff [NUM_CHAN];
   logic [15:0]        out_in [NUM_CHAN];
   logic [15:0]        out_ff [NUM_CHAN];

   assign rdy3     = !v3_ff || !rsp_stall;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // Stage 1: fraction times channel step
   always_comb begin
      logic [15:0]        c1;
      logic signed [16:0] diff;
      frac = ratio_pick(in_cls, in_quot);
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         c0[ch] = level_word[IDX_W'(in_lev)][chan_lsb(ch) +: 16];
         c1     = level_word[IDX_W'({1'b0, in_lev} + 3'd1)][chan_lsb(ch) +: 16];
         diff   = $signed({1'b0, c1}) - $signed({1'b0, c0[ch]});
         prod_in[ch] = $signed({1'b0, frac}) * diff;
      end
   end

   // Stage 2: add the segment base, drop negatives
   always_comb begin
      logic signed [34:0] sum;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         sum = $signed({3'b000, c0_ff[ch], 16'h0000}) + 35'(prod_ff[ch]);
         v_in[ch] = (sum < 0) ? 32'd0 : sum[31:0];
      end
   end

   // Stage 3: times 255, keep the Q8.8 part
   always_comb begin
      logic [39:0] w;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         w = {v_ff[ch], 8'h00} - {8'h00, v_ff[ch]};
         out_in[ch] = w[39:24];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
      if (rdy1 && in_valid) begin
         prod_ff  <= prod_in;
         c0_ff    <= c0;
         frac1_ff <= frac;
         lev1_ff  <= in_lev;
      end
      if (rdy2 && v1_ff) begin
         v_ff     <= v_in;
         frac2_ff <= frac1_ff;
         lev2_ff  <= lev1_ff;
      end
      if (rdy3 && v2_ff) begin
         out_ff   <= out_in;
         frac3_ff <= frac2_ff;
         lev3_ff  <= lev2_ff;
      end
   end

   assign rsp_valid            = v3_ff;
   assign rsp_red              = out_ff[0];
   assign rsp_green            = out_ff[1];
   assign rsp_blue             = out_ff[2];
   assign rsp_segment_index    = lev3_ff;
   assign rsp_segment_fraction = frac3_ff;

endmodule

// ===== hw/rtl/gray_to_rgb_colormap_ramp_core.sv =====
// Top level of the gray-to-RGB colormap ramp: registers and pipeline wiring.
`timescale 1ns / 1ps
// One pixel enters per clock while req_stall is low. Its RGB result passes
// through 37 register stages (front stage, 16-stage normalization divider,
// segment stage, 16-stage fraction divider, three shading stages). Every
// stage holds its own valid bit and a stage takes a new item whenever it is
// empty or its item moves on, so bubbles close up while the output is
// stalled. The register port may be written only while no item is in flight;
// the pipeline reads the registers live.
module gray_to_rgb_colormap_ramp_core #(
   parameter int MAX_LEVELS = cgr_pkg::MAX_LEVELS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [31:0]  req_pixel,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [15:0]  rsp_red,
   output logic [15:0]  rsp_green,
   output logic [15:0]  rsp_blue,
   output logic [1:0]   rsp_segment_index,
   output logic [15:0]  rsp_segment_fraction,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata
);
   import cgr_pkg::*;

   logic signed [31:0] range_low_ff, range_high_ff;
   logic [2:0]         level_count_ff;
   logic [63:0]        level_ff [MAX_LEVELS];
   logic [2:0]         level_num;

   logic               norm_ready, norm_valid, d1_ready, d1_valid;
   logic [32:0]        norm_num, norm_den;
   cls_type            norm_cls;
   logic [QBITS-1:0]   d1_quot;
   logic [1:0]         d1_side;
   logic               seg_ready, seg_valid, d2_ready, d2_valid, shade_ready;
   logic [15:0]        seg_num, seg_den;
   cls_type            seg_cls;
   logic [1:0]         seg_lev;
   logic [QBITS-1:0]   d2_quot;
   logic [3:0]         d2_side;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff   <= 32'sd0;
         range_high_ff  <= 32'sd255;
         level_count_ff <= 3'd2;
         for (int k = 0; k < MAX_LEVELS; k++) begin
            level_ff[k] <= (k == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0;
         end
      end else if (csr_we) begin
         if (csr_index == CSR_RANGE_LOW)   range_low_ff   <= csr_wdata[31:0];
         if (csr_index == CSR_RANGE_HIGH)  range_high_ff  <= csr_wdata[31:0];
         if (csr_index == CSR_LEVEL_COUNT) level_count_ff <= csr_wdata[2:0];
         for (int k = 0; k < MAX_LEVELS; k++) begin
            if (csr_index == CSR_LEVEL_0 + 3'(k)) level_ff[k] <= csr_wdata;
         end
      end
   end

   // Clamp the level count into the supported range
   always_comb begin
      if (level_count_ff < 3'd2) begin
         level_num = 3'd2;
      end else if (level_count_ff > 3'(MAX_LEVELS)) begin
         level_num = 3'(MAX_LEVELS);
      end else begin
         level_num = level_count_ff;
      end
   end

   assign req_stall = !norm_ready;

   cgr_norm u_norm (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (norm_ready),
      .pixel      (req_pixel),
      .range_low  (range_low_ff),
      .range_high (range_high_ff),
      .out_valid  (norm_valid),
      .out_ready  (d1_ready),
      .out_num    (norm_num),
      .out_den    (norm_den),
      .out_cls    (norm_cls)
   );

   cgr_div #(.W(33), .SB(2)) u_div_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_ready  (d1_ready),
      .in_num    (norm_num),
      .in_den    (norm_den),
      .in_side   (norm_cls),
      .out_valid (d1_valid),
      .out_ready (seg_ready),
      .out_quot  (d1_quot),
      .out_side  (d1_side)
   );

   cgr_seg #(.MAX_LEVELS(MAX_LEVELS)) u_seg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (d1_valid),
      .in_ready   (seg_ready),
      .in_quot    (d1_quot),
      .in_cls     (cls_type'(d1_side)),
      .level_word (level_ff),
      .level_num  (level_num),
      .out_valid  (seg_valid),
      .out_ready  (d2_ready),
      .out_num    (seg_num),
      .out_den    (seg_den),
      .out_cls    (seg_cls),
      .out_lev    (seg_lev)
   );

   cgr_div #(.W(16), .SB(4)) u_div_frac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (seg_valid),
      .in_ready  (d2_ready),
      .in_num    (seg_num),
      .in_den    (seg_den),
      .in_side   ({seg_cls, seg_lev}),
      .out_valid (d2_valid),
      .out_ready (shade_ready),
      .out_quot  (d2_quot),
      .out_side  (d2_side)
   );

   cgr_shade #(.MAX_LEVELS(MAX_LEVELS)) u_shade (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (d2_valid),
      .in_ready             (shade_ready),
      .in_quot              (d2_quot),
      .in_cls               (cls_type'(d2_side[3:2])),
      .in_lev               (d2_side[1:0]),
      .level_word           (level_ff),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_red              (rsp_red),
      .rsp_green            (rsp_green),
      .rsp_blue             (rsp_blue),
      .rsp_segment_index    (rsp_segment_index),
      .rsp_segment_fraction (rsp_segment_fraction)
   );

`ifndef SYNTHESIS
   // The chosen segment never starts at or past the last level in use
   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_segment_index} <= level_num - 3'd2))
      else $error("segment index beyond level count");

   // Scaling by 255 keeps every channel at or below 0xFF00
   a_chan_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red <= 16'hFF00 && rsp_green <= 16'hFF00 &&
                     rsp_blue <= 16'hFF00))
      else $error("channel above scaled maximum");

   // Nothing leaves the pipeline in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
